[rtl/core/at_sch_pkg.sv]
// Shared types and codes of the modem command scheduler.
package at_sch_pkg;

  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_LOOP_INTERVAL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COOLDOWN_INTERVAL = 2'd1;

  localparam logic [2:0] KIND_TICK = 3'd0;
  localparam logic [2:0] KIND_ENQUEUE = 3'd1;
  localparam logic [2:0] KIND_REGISTER = 3'd2;
  localparam logic [2:0] KIND_SET_MODE = 3'd3;
  localparam logic [2:0] KIND_RESPONSE = 3'd4;

  localparam logic [2:0] EV_NONE = 3'd0;
  localparam logic [2:0] EV_ACCEPTED = 3'd1;
  localparam logic [2:0] EV_REJECTED = 3'd2;
  localparam logic [2:0] EV_ISSUED = 3'd3;
  localparam logic [2:0] EV_DONE = 3'd4;
  localparam logic [2:0] EV_TIMEOUT = 3'd5;

  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_SEND = 3'd1;
  localparam logic [2:0] PH_WAIT = 3'd2;
  localparam logic [2:0] PH_OK = 3'd3;
  localparam logic [2:0] PH_TIMEOUT = 3'd4;

  localparam logic [31:0] NEVER_RUN_ELAPSED = 32'hFFFF_FFFF;

  typedef enum logic [2:0] {
    OP_TICK,
    OP_ENQUEUE,
    OP_REGISTER,
    OP_SET_MODE,
    OP_RESPONSE,
    OP_IGNORE
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [7:0]  cmd_id;
    logic [15:0] timeout_ticks;
    logic [15:0] interval_ticks;
    logic [3:0]  mode_value;
  } item_t;

  typedef struct packed {
    logic [2:0] event_res;
    logic [7:0] issued_cmd;
    logic       from_table;
    logic [2:0] engine_phase;
    logic [3:0] queue_level;
  } result_t;

  typedef struct packed {
    logic [15:0] loop_interval;
    logic [15:0] cooldown_interval;
  } cfg_regs_t;

endpackage

[rtl/core/at_sch_if.sv]
// Channel interfaces of the scheduler: input items, results and configuration writes.
interface at_sch_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [7:0]  cmd_id;
  logic [15:0] timeout_ticks;
  logic [15:0] interval_ticks;
  logic [3:0]  mode_value;
  modport source (output valid, kind, cmd_id, timeout_ticks, interval_ticks, mode_value,
                  input ready);
  modport sink (input valid, kind, cmd_id, timeout_ticks, interval_ticks, mode_value,
                output ready);
endinterface

interface at_sch_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] event_res;
  logic [7:0] issued_cmd;
  logic       from_table;
  logic [2:0] engine_phase;
  logic [3:0] queue_level;
  modport source (output valid, event_res, issued_cmd, from_table, engine_phase, queue_level,
                  input ready);
  modport sink (input valid, event_res, issued_cmd, from_table, engine_phase, queue_level,
                output ready);
endinterface

interface at_sch_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[rtl/core/at_command_scheduler_top.sv]
// Top level of the modem command scheduler.
// Each input beat gives exactly one result beat. Enqueue, register, mode and response
// beats are handled in the take state of the back end, and so is a tick, except a poll in
// the idle phase with an empty ring, which scans the monitor table one entry per cycle and
// then gives its result from a final state. A two-entry queue sits between the front end
// and the back end; while a result waits to be taken, the back end holds the next item in
// that queue. Configuration writes are taken in every cycle and belong to idle periods.
module at_command_scheduler_top #(
  parameter int TABLE_DEPTH = 16,
  parameter int RING_DEPTH = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  at_sch_in_if.sink    in_ch,
  at_sch_out_if.source out_ch,
  at_sch_cfg_if.sink   cfg_ch
);
  import at_sch_pkg::*;

  cfg_regs_t cfg_r;
  item_t     item;
  logic      item_valid;
  logic      item_pop;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.loop_interval <= 16'd1;
      cfg_r.cooldown_interval <= 16'd1;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        CFG_LOOP_INTERVAL:     cfg_r.loop_interval <= cfg_ch.data;
        CFG_COOLDOWN_INTERVAL: cfg_r.cooldown_interval <= cfg_ch.data;
        default: begin
        end
      endcase
    end
  end

  at_sch_front u_front (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch),
    .item_valid(item_valid), .item(item), .item_pop(item_pop)
  );

  at_sch_back #(.TABLE_DEPTH(TABLE_DEPTH), .RING_DEPTH(RING_DEPTH)) u_back (
    .clk(clk), .rst_n(rst_n), .cfg(cfg_r),
    .item_valid(item_valid), .item(item), .item_pop(item_pop), .out_ch(out_ch)
  );
endmodule

[rtl/core/at_sch_front.sv]
// Front end: accepts input beats, decodes the kind and queues items for the back end.
module at_sch_front (
  input  logic            clk,
  input  logic            rst_n,
  at_sch_in_if.sink       in_ch,
  output logic            item_valid,
  output at_sch_pkg::item_t item,
  input  logic            item_pop
);
  import at_sch_pkg::*;

  item_t      buf_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  item_t      dec;
  logic       push;

  always_comb begin
    dec.cmd_id = in_ch.cmd_id;
    dec.timeout_ticks = in_ch.timeout_ticks;
    dec.interval_ticks = in_ch.interval_ticks;
    dec.mode_value = in_ch.mode_value;
    case (in_ch.kind)
      KIND_TICK:     dec.op = OP_TICK;
      KIND_ENQUEUE:  dec.op = OP_ENQUEUE;
      KIND_REGISTER: dec.op = OP_REGISTER;
      KIND_SET_MODE: dec.op = OP_SET_MODE;
      KIND_RESPONSE: dec.op = OP_RESPONSE;
      default:       dec.op = OP_IGNORE;
    endcase
  end

  assign in_ch.ready = (cnt_r != 2'd2);
  assign push = in_ch.valid && in_ch.ready;
  assign item_valid = (cnt_r != 2'd0);
  assign item = buf_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = item_pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, item_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push) begin
      buf_r[wr_ptr_r] <= dec;
    end
  end
endmodule

[rtl/core/at_sch_back.sv]
// Back end: ring, monitor table, poll engine with a one-entry-per-cycle table scan.
module at_sch_back #(
  parameter int TABLE_DEPTH = 16,
  parameter int RING_DEPTH = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  at_sch_pkg::cfg_regs_t cfg,
  input  logic                  item_valid,
  input  at_sch_pkg::item_t     item,
  output logic                  item_pop,
  at_sch_out_if.source          out_ch
);
  import at_sch_pkg::*;

  localparam int TIDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int RIDX_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int RCNT_W = $clog2(RING_DEPTH + 1);

  typedef enum logic [1:0] {ST_TAKE, ST_SCAN, ST_FIN} st_t;

  st_t st_r;

  logic [31:0] tick_r, last_poll_r, last_send_r;
  logic [2:0]  phase_r;
  logic [7:0]  act_cmd_r;
  logic [15:0] act_tmo_r;
  logic        reply_r;
  logic [3:0]  cur_mode_r;

  logic [7:0]  ring_cmd_r [RING_DEPTH];
  logic [15:0] ring_tmo_r [RING_DEPTH];
  logic [RIDX_W-1:0] head_r, tail_r;
  logic [RCNT_W-1:0] rcnt_r;

  logic [7:0]  tab_cmd_r [TABLE_DEPTH];
  logic [3:0]  tab_mode_r [TABLE_DEPTH];
  logic [15:0] tab_ivl_r [TABLE_DEPTH];
  logic [15:0] tab_tmo_r [TABLE_DEPTH];
  logic [31:0] tab_lr_r [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] tab_vld_r;

  logic [TIDX_W-1:0] scan_idx_r, pick_r;
  logic [31:0] best_r;
  logic        found_r;
  logic [7:0]  best_cmd_r;
  logic [15:0] best_tmo_r;

  logic        out_valid_r;
  result_t     out_r;
  logic        out_free;

  logic [31:0] now, gap;
  logic        poll_due;
  logic        free_found;
  logic [TIDX_W-1:0] free_idx;
  logic [31:0] el;
  logic        cand;

  function automatic logic [RIDX_W-1:0] ring_inc(input logic [RIDX_W-1:0] p);
    ring_inc = (p == RIDX_W'(RING_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign out_free = !out_valid_r || out_ch.ready;
  assign item_pop = (st_r == ST_TAKE) && item_valid && out_free;

  assign now = tick_r + 32'd1;
  assign gap = {16'd0, (phase_r == PH_OK) ? cfg.cooldown_interval : cfg.loop_interval};
  assign poll_due = (now - last_poll_r) >= gap;

  always_comb begin
    free_found = 1'b0;
    free_idx = '0;
    for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
      if (!tab_vld_r[i]) begin
        free_found = 1'b1;
        free_idx = TIDX_W'(i);
      end
    end
  end

  always_comb begin
    el = (tab_lr_r[scan_idx_r] == 32'd0) ? NEVER_RUN_ELAPSED
                                         : tick_r - tab_lr_r[scan_idx_r];
    cand = tab_vld_r[scan_idx_r] && (tab_mode_r[scan_idx_r] == cur_mode_r) &&
           ((tab_ivl_r[scan_idx_r] == 16'd0) || (el >= {16'd0, tab_ivl_r[scan_idx_r]})) &&
           (el > best_r);
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.event_res = out_r.event_res;
  assign out_ch.issued_cmd = out_r.issued_cmd;
  assign out_ch.from_table = out_r.from_table;
  assign out_ch.engine_phase = out_r.engine_phase;
  assign out_ch.queue_level = out_r.queue_level;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_TAKE;
      tick_r <= '0;
      last_poll_r <= '0;
      last_send_r <= '0;
      phase_r <= PH_IDLE;
      act_cmd_r <= '0;
      act_tmo_r <= '0;
      reply_r <= 1'b0;
      cur_mode_r <= '0;
      head_r <= '0;
      tail_r <= '0;
      rcnt_r <= '0;
      tab_vld_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      case (st_r)
        ST_TAKE: begin
          if (item_pop) begin
            out_r <= '{EV_NONE, 8'd0, 1'b0, phase_r, 4'(rcnt_r)};
            out_valid_r <= 1'b1;
            case (item.op)
              OP_TICK: begin
                tick_r <= now;
                if (poll_due) begin
                  last_poll_r <= now;
                  case (phase_r)
                    PH_IDLE: begin
                      if (rcnt_r != '0) begin
                        head_r <= ring_inc(head_r);
                        rcnt_r <= rcnt_r - 1'b1;
                        act_cmd_r <= ring_cmd_r[head_r];
                        act_tmo_r <= ring_tmo_r[head_r];
                        reply_r <= 1'b0;
                        last_send_r <= now;
                        phase_r <= PH_SEND;
                        out_r <= '{EV_ISSUED, ring_cmd_r[head_r], 1'b0, PH_SEND,
                                   4'(rcnt_r - 1'b1)};
                      end else begin
                        out_valid_r <= 1'b0;
                        scan_idx_r <= '0;
                        best_r <= '0;
                        found_r <= 1'b0;
                        st_r <= ST_SCAN;
                      end
                    end
                    PH_SEND: begin
                      phase_r <= PH_WAIT;
                      out_r.engine_phase <= PH_WAIT;
                    end
                    PH_WAIT: begin
                      if (reply_r) begin
                        reply_r <= 1'b0;
                        phase_r <= PH_OK;
                        out_r <= '{EV_DONE, act_cmd_r, 1'b0, PH_OK, 4'(rcnt_r)};
                      end else if ((now - last_send_r) >= {16'd0, act_tmo_r}) begin
                        phase_r <= PH_TIMEOUT;
                        out_r.engine_phase <= PH_TIMEOUT;
                      end
                    end
                    PH_OK: begin
                      reply_r <= 1'b0;
                      phase_r <= PH_IDLE;
                      out_r.engine_phase <= PH_IDLE;
                    end
                    PH_TIMEOUT: begin
                      reply_r <= 1'b0;
                      phase_r <= PH_IDLE;
                      out_r <= '{EV_TIMEOUT, act_cmd_r, 1'b0, PH_IDLE, 4'(rcnt_r)};
                    end
                    default: begin
                      phase_r <= PH_IDLE;
                      out_r.engine_phase <= PH_IDLE;
                    end
                  endcase
                end
              end
              OP_ENQUEUE: begin
                if (rcnt_r >= RCNT_W'(RING_DEPTH)) begin
                  out_r.event_res <= EV_REJECTED;
                end else begin
                  ring_cmd_r[tail_r] <= item.cmd_id;
                  ring_tmo_r[tail_r] <= item.timeout_ticks;
                  tail_r <= ring_inc(tail_r);
                  rcnt_r <= rcnt_r + 1'b1;
                  out_r.event_res <= EV_ACCEPTED;
                  out_r.queue_level <= 4'(rcnt_r + 1'b1);
                end
              end
              OP_REGISTER: begin
                if (free_found) begin
                  tab_cmd_r[free_idx] <= item.cmd_id;
                  tab_mode_r[free_idx] <= item.mode_value;
                  tab_ivl_r[free_idx] <= item.interval_ticks;
                  tab_tmo_r[free_idx] <= item.timeout_ticks;
                  tab_lr_r[free_idx] <= '0;
                  tab_vld_r[free_idx] <= 1'b1;
                  out_r.event_res <= EV_ACCEPTED;
                end else begin
                  out_r.event_res <= EV_REJECTED;
                end
              end
              OP_SET_MODE: begin
                cur_mode_r <= item.mode_value;
                out_r.event_res <= EV_ACCEPTED;
              end
              OP_RESPONSE: begin
                reply_r <= 1'b1;
                out_r.event_res <= EV_ACCEPTED;
              end
              default: begin
              end
            endcase
          end
        end
        ST_SCAN: begin
          if (cand) begin
            best_r <= el;
            pick_r <= scan_idx_r;
            found_r <= 1'b1;
            best_cmd_r <= tab_cmd_r[scan_idx_r];
            best_tmo_r <= tab_tmo_r[scan_idx_r];
          end
          if (scan_idx_r == TIDX_W'(TABLE_DEPTH - 1)) begin
            st_r <= ST_FIN;
          end else begin
            scan_idx_r <= scan_idx_r + 1'b1;
          end
        end
        ST_FIN: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            st_r <= ST_TAKE;
            if (found_r) begin
              tab_lr_r[pick_r] <= tick_r;
              act_cmd_r <= best_cmd_r;
              act_tmo_r <= best_tmo_r;
              reply_r <= 1'b0;
              last_send_r <= tick_r;
              phase_r <= PH_SEND;
              out_r <= '{EV_ISSUED, best_cmd_r, 1'b1, PH_SEND, 4'(rcnt_r)};
            end else begin
              out_r <= '{EV_NONE, 8'd0, 1'b0, phase_r, 4'(rcnt_r)};
            end
          end
        end
        default: st_r <= ST_TAKE;
      endcase
    end
  end
endmodule

[rtl/core/at_sch_checker.sv]
// Port-level checker of the scheduler and its bind to the top level.
module at_sch_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] event_res,
  input logic       from_table,
  input logic [2:0] engine_phase,
  input logic [3:0] queue_level
);
  import at_sch_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(event_res))
    else $error("result dropped while stalled");

  a_issue_phase: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && event_res == EV_ISSUED |-> engine_phase == PH_SEND)
    else $error("issued command without send phase");

  a_table_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && from_table |-> event_res == EV_ISSUED)
    else $error("table flag on a non-issue event");

  a_timeout_phase: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && event_res == EV_TIMEOUT |-> engine_phase == PH_IDLE && queue_level <= 4'd8)
    else $error("timeout event left engine busy");
endmodule

bind at_command_scheduler_top at_sch_checker u_chk (
  .clk(clk), .rst_n(rst_n), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .event_res(out_ch.event_res), .from_table(out_ch.from_table),
  .engine_phase(out_ch.engine_phase), .queue_level(out_ch.queue_level)
);
